// ===== hdl/rtmh_pkg.sv =====
// Shared types, constants and codes for the relative-time min-heap scheduler.
// No dependencies.
package rtmh_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = IDX_W + 2;
    localparam int KEY_W    = 16;
    localparam int ID_W     = 16;
    localparam int OCC_W    = 7;
    localparam int STAT_W   = 2;

    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [ID_W-1:0]    t_id;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [CHILD_W-1:0] t_child;
    typedef logic [STAT_W-1:0]  t_status;

    localparam logic    OP_INSERT  = 1'b0;
    localparam logic    OP_EXTRACT = 1'b1;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam t_cnt CNT_FULL = t_cnt'(CAPACITY);

    // Keys are held in memory as absolute times (relative key + time offset).
    typedef struct packed {
        t_key key;
        t_id  id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        t_entry wdata;
        t_idx   raddr_a;
        t_idx   raddr_b;
    } t_mem_req;

    typedef struct packed {
        t_id        served_id;
        t_status    status;
        logic [OCC_W-1:0] occupancy;
    } t_result;

endpackage

// ===== hdl/rtmh_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module rtmh_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== hdl/rtmh_ctrl.sv =====
// Heap sequencer: sift-up on insert, sift-down on extract, time-offset rebasing.
// Depends on rtmh_pkg; drives the entry RAM through a t_mem_req struct.
module rtmh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_op,
    input  rtmh_pkg::t_id    i_id,
    input  rtmh_pkg::t_key   i_delay,
    output logic             o_busy,
    output rtmh_pkg::t_mem_req o_mem,
    input  rtmh_pkg::t_entry i_rdata_a,
    input  rtmh_pkg::t_entry i_rdata_b,
    output logic             o_done,
    output rtmh_pkg::t_result o_res,
    input  logic             i_out_free
);
    import rtmh_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP     = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_EX     = 3'd3;
    localparam logic [2:0] S_DN     = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state, n_state;
    t_cnt       r_count, n_count;
    t_key       r_off, n_off;
    t_idx       r_pos, n_pos;
    t_key       r_key, n_key;     // moving item's key, relative to r_off
    t_id        r_id, n_id;
    t_id        r_served, n_served;
    t_status    r_status, n_status;

    logic       acc;
    t_idx       parent;
    t_child     left, right;
    t_key       rel_a, rel_b;
    logic       right_ok, pick_right;
    t_key       best_rel;
    t_entry     best_ent;
    t_entry     item;

    assign acc    = i_valid && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    assign parent     = (r_pos - t_idx'(1)) >> 1;
    assign left       = (t_child'(r_pos) << 1) + t_child'(1);
    assign right      = left + t_child'(1);
    assign rel_a      = i_rdata_a.key - r_off;
    assign rel_b      = i_rdata_b.key - r_off;
    assign right_ok   = right < t_child'(r_count);
    assign pick_right = right_ok && (rel_b < rel_a);
    assign best_rel   = pick_right ? rel_b : rel_a;
    assign best_ent   = pick_right ? i_rdata_b : i_rdata_a;
    assign item.key   = r_key + r_off;
    assign item.id    = r_id;

    assign o_res.served_id = r_served;
    assign o_res.status    = r_status;
    assign o_res.occupancy = OCC_W'(r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_off    = r_off;
        n_pos    = r_pos;
        n_key    = r_key;
        n_id     = r_id;
        n_served = r_served;
        n_status = r_status;

        o_mem.we      = 1'b0;
        o_mem.waddr   = r_pos;
        o_mem.wdata   = item;
        o_mem.raddr_a = '0;
        o_mem.raddr_b = t_idx'(r_count - t_cnt'(1));

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_served = '0;
                    n_status = ST_OK;
                    if (i_op == OP_INSERT) begin
                        if (r_count == CNT_FULL) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_count = r_count + t_cnt'(1);
                            n_pos   = t_idx'(r_count);
                            n_key   = i_delay;
                            n_id    = i_id;
                            n_state = S_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            // root and last entry are read on ports a and b
                            n_count = r_count - t_cnt'(1);
                            n_state = S_EX;
                        end
                    end
                end
            end
            S_UP: begin
                if (r_pos == '0) begin
                    o_mem.we = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    o_mem.raddr_a = parent;
                    n_state       = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_mem.we = 1'b1;
                if (rel_a > r_key) begin
                    o_mem.wdata = i_rdata_a;
                    n_pos       = parent;
                    n_state     = S_UP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EX: begin
                // new time base is the root's absolute key
                n_served = i_rdata_a.id;
                n_off    = i_rdata_a.key;
                n_key    = i_rdata_b.key - i_rdata_a.key;
                n_id     = i_rdata_b.id;
                n_pos    = '0;
                n_state  = (r_count == '0) ? S_DONE : S_DN;
            end
            S_DN: begin
                if (left >= t_child'(r_count)) begin
                    o_mem.we = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    o_mem.raddr_a = t_idx'(left);
                    o_mem.raddr_b = t_idx'(right);
                    n_state       = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                o_mem.we = 1'b1;
                if (r_key > best_rel) begin
                    o_mem.wdata = best_ent;
                    n_pos       = pick_right ? t_idx'(right) : t_idx'(left);
                    n_state     = S_DN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_off   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_off   <= n_off;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_id     <= n_id;
        r_served <= n_served;
        r_status <= n_status;
    end

`ifndef SYNTH
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !o_mem.we)
        else $error("heap memory written outside a sift walk");

    a_full_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_op == OP_INSERT && r_count == CNT_FULL)
            |=> (r_state == S_DONE && r_status == ST_FULL && $stable(r_count)))
        else $error("insert into full heap not rejected");

    a_extract_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_op == OP_EXTRACT && r_count != '0)
            |=> (r_count == $past(r_count) - t_cnt'(1)))
        else $error("extract did not drop the entry count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_count <= CNT_FULL))
        else $error("entry count above capacity");
`endif

endmodule

// ===== hdl/relative_time_min_heap_scheduler.sv =====
// Relative-time min-heap scheduler, top level: sequencer, entry RAM, result register.
// Depends on rtmh_pkg, rtmh_ctrl and rtmh_ram.
//
// Request channel (i_valid/o_stall): operation 0 inserts (actor_id, delay),
// operation 1 extracts the entry with the smallest delay. One request is worked
// at a time; o_stall is high from acceptance until the result is handed to the
// result register.
// Result channel (o_valid/i_stall): one result per request with the served id
// (0 on insert or error), a status (ok, extract from empty, insert into full)
// and the occupancy after the request.
// An insert climbs from the new last slot toward the root; an extract reads the root
// and the last entry, moves the last entry to the root and sinks it. Errors and the
// extract of the only entry skip the walk. A new request is taken in the cycle after
// the result is handed over; each heap level costs a read and a write.
// Rebasing on extract is free: keys are stored as absolute times against an offset.
// Reset empties the heap at once; the RAM contents need no clearing.
// While the receiver stalls, a held result stays in the result register and
// the next request is still accepted and worked; it waits in the sequencer
// until the result register frees up.
module relative_time_min_heap_scheduler (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_operation,
    input  rtmh_pkg::t_id            i_actor_id,
    input  rtmh_pkg::t_key           i_delay,
    output logic                     o_valid,
    input  logic                     i_stall,
    output rtmh_pkg::t_id            o_served_id,
    output rtmh_pkg::t_status        o_status,
    output logic [rtmh_pkg::OCC_W-1:0] o_occupancy
);
    import rtmh_pkg::*;

    t_mem_req mem_req;
    t_entry   rdata_a, rdata_b;
    logic     busy, done, out_free;
    t_result  res;

    logic     r_ovalid;
    t_result  r_res;

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = busy;

    rtmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_op       (i_operation),
        .i_id       (i_actor_id),
        .i_delay    (i_delay),
        .o_busy     (busy),
        .o_mem      (mem_req),
        .i_rdata_a  (rdata_a),
        .i_rdata_b  (rdata_b),
        .o_done     (done),
        .o_res      (res),
        .i_out_free (out_free)
    );

    rtmh_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_req.we),
        .i_waddr   (mem_req.waddr),
        .i_wdata   (mem_req.wdata),
        .i_raddr_a (mem_req.raddr_a),
        .i_raddr_b (mem_req.raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && out_free) begin
            r_res <= res;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_served_id = r_res.served_id;
    assign o_status    = r_res.status;
    assign o_occupancy = r_res.occupancy;

endmodule
